@@ rtl/sfsm_pkg.sv @@
package sfsm_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;

    localparam int OFF_W  = 48;
    localparam int CNT_W  = 32;
    localparam int PHYS_W = 56;
    localparam int LEN_W  = 31;
    localparam int POS_W  = 47;
    localparam int END_W  = 48;
    localparam int BLK_W  = 39;
    localparam int ALU_W  = 56;
    localparam int MASK_W = 30;
    localparam int PROD_W = 48;
    localparam int SH_W   = 5;
    localparam int CH_W   = 9;
    localparam int IDX_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [2:0] CMD_XFER_AT_OFFSET = 3'd0;
    localparam logic [2:0] CMD_XFER_AT_POS    = 3'd1;
    localparam logic [2:0] CMD_SEEK_SET       = 3'd2;
    localparam logic [2:0] CMD_SEEK_CUR       = 3'd3;
    localparam logic [2:0] CMD_SEEK_END       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_INDEX = 2'd2;

    localparam logic [SH_W-1:0]  BS_MIN   = 5'd9;
    localparam logic [SH_W-1:0]  BS_MAX   = 5'd30;
    localparam logic [SH_W-1:0]  BS_RESET = 5'd23;
    localparam logic [CH_W-1:0]  CH_MAX   = 9'd256;
    localparam logic [CH_W-1:0]  CH_RESET = 9'd1;
    localparam logic [IDX_W-1:0] IDX_RESET = 8'd0;
    localparam logic [CNT_W-1:0] MAX_SEG_LEN = 32'h4000_0000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SPAN = 2'd1,
        ST_NEG  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DEC,
        S_SPAN,
        S_MUL,
        S_SEG
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_MAC
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
        logic              cin;
        logic [IDX_W-1:0]  c;
    } t_alu_req;

    typedef struct packed {
        logic [SH_W-1:0]   shift;
        logic [CH_W-1:0]   count;
        logic [IDX_W-1:0]  index;
        logic [MASK_W-1:0] mask;
        logic [MASK_W:0]   size;
    } t_cfg;

endpackage

@@ rtl/sfsm_alu.sv @@
module sfsm_alu (
    input  sfsm_pkg::t_alu_req               i_req,
    output logic [sfsm_pkg::ALU_W-1:0]       o_result
);

    logic [sfsm_pkg::PROD_W-1:0] w_prod;

    // 39x9 multiply plus channel slot: block number times stride
    assign w_prod = sfsm_pkg::PROD_W'(i_req.a[sfsm_pkg::BLK_W-1:0])
                  * sfsm_pkg::PROD_W'(i_req.b[sfsm_pkg::CH_W-1:0])
                  + sfsm_pkg::PROD_W'(i_req.c);

    always_comb begin
        unique case (i_req.op)
            sfsm_pkg::ALU_ADD: o_result = i_req.a + i_req.b + sfsm_pkg::ALU_W'(i_req.cin);
            sfsm_pkg::ALU_MAC: o_result = sfsm_pkg::ALU_W'(w_prod);
            default:           o_result = '0;
        endcase
    end

endmodule

@@ rtl/sfsm_cfg.sv @@
module sfsm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_write,
    input  logic [sfsm_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [sfsm_pkg::CFG_DATA_W-1:0]     i_data,
    output sfsm_pkg::t_cfg                      o_cfg
);

    logic [sfsm_pkg::SH_W-1:0]  r_shift;
    logic [sfsm_pkg::CH_W-1:0]  r_count;
    logic [sfsm_pkg::IDX_W-1:0] r_index;

    logic [sfsm_pkg::SH_W-1:0]  w_shift;
    logic [sfsm_pkg::CH_W-1:0]  w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= sfsm_pkg::BS_RESET;
            r_count <= sfsm_pkg::CH_RESET;
            r_index <= sfsm_pkg::IDX_RESET;
        end else if (i_write) begin
            unique case (i_index)
                sfsm_pkg::CFG_BLOCK_SHIFT:   r_shift <= i_data[sfsm_pkg::SH_W-1:0];
                sfsm_pkg::CFG_CHANNEL_COUNT: r_count <= i_data[sfsm_pkg::CH_W-1:0];
                sfsm_pkg::CFG_CHANNEL_INDEX: r_index <= i_data[sfsm_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range settings are clamped on the read side
    always_comb begin
        priority if (r_shift < sfsm_pkg::BS_MIN) w_shift = sfsm_pkg::BS_MIN;
        else if (r_shift > sfsm_pkg::BS_MAX)     w_shift = sfsm_pkg::BS_MAX;
        else                                     w_shift = r_shift;

        priority if (r_count == '0)          w_count = sfsm_pkg::CH_RESET;
        else if (r_count > sfsm_pkg::CH_MAX) w_count = sfsm_pkg::CH_MAX;
        else                                 w_count = r_count;
    end

    assign o_cfg.shift = w_shift;
    assign o_cfg.count = w_count;
    assign o_cfg.index = ({1'b0, r_index} >= w_count)
                       ? sfsm_pkg::IDX_W'(w_count - sfsm_pkg::CH_W'(1)) : r_index;
    assign o_cfg.mask  = {sfsm_pkg::MASK_W{1'b1}} >> (sfsm_pkg::BS_MAX - w_shift);
    assign o_cfg.size  = (sfsm_pkg::MASK_W+1)'(1) << w_shift;

endmodule

@@ rtl/striped_file_segment_mapper.sv @@
// Striped file segment mapper. Pulse start while busy is low to hand in a
// transfer or seek; busy stays high while the request is worked on and drops
// at the edge that puts its final result on the ports. Results come out on
// o_strobe, each for a single cycle, and cannot be held off, so the receiver
// must take every transaction as it appears; o_last marks the final one of a
// request. Seeks, unknown commands and negative-start refusals give one
// result, registered from the sum state. A transfer walks a sequencer around
// one shared adder/multiplier through sum, decrement and span states: with
// one channel the single result comes from the span state, otherwise a
// multiply state follows and the segment state gives the N segments back to
// back, where N (1 to MAX_SEGMENTS) is the number of blocks spanned, the last
// one at the edge at which busy drops. The span state refuses more than
// MAX_SEGMENTS blocks, or with one channel more than MAX_SEG_LEN bytes, with
// one result. Configuration writes are taken whenever busy is low.
module striped_file_segment_mapper #(
    parameter int MAX_SEGMENTS = sfsm_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sfsm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sfsm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [2:0]                             i_command,
    input  logic                                   i_is_write,
    input  logic signed [sfsm_pkg::OFF_W-1:0]      i_offset,
    input  logic [sfsm_pkg::CNT_W-1:0]             i_byte_count,
    output logic                                   o_strobe,
    output logic [sfsm_pkg::PHYS_W-1:0]            o_phys_offset,
    output logic [sfsm_pkg::LEN_W-1:0]             o_seg_length,
    output logic                                   o_seg_write,
    output logic                                   o_last,
    output logic [1:0]                             o_status,
    output logic [sfsm_pkg::POS_W-1:0]             o_position
);

    localparam int LEFT_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ALU_W  = sfsm_pkg::ALU_W;
    localparam int POS_W  = sfsm_pkg::POS_W;
    localparam int END_W  = sfsm_pkg::END_W;
    localparam int BLK_W  = sfsm_pkg::BLK_W;
    localparam int MASK_W = sfsm_pkg::MASK_W;
    localparam int PROD_W = sfsm_pkg::PROD_W;

    sfsm_pkg::t_cfg     w_cfg;
    sfsm_pkg::t_alu_req w_req;
    logic [ALU_W-1:0]   w_sum;

    sfsm_pkg::t_state   r_state, n_state;
    logic [2:0]                   r_cmd, n_cmd;
    logic                         r_wr, n_wr;
    logic [sfsm_pkg::OFF_W-1:0]   r_off, n_off;
    logic [sfsm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [END_W-1:0]             r_lend, n_lend;
    logic [POS_W-1:0]             r_start, n_start;
    logic [END_W-1:0]             r_end, n_end;
    logic [BLK_W-1:0]             r_lastb, n_lastb;
    logic [PROD_W-1:0]            r_blk, n_blk;
    logic [LEFT_W-1:0]            r_left, n_left;
    logic                         r_first, n_first;

    logic                         r_strobe, n_strobe;
    logic [sfsm_pkg::PHYS_W-1:0]  r_phys, n_phys;
    logic [sfsm_pkg::LEN_W-1:0]   r_len, n_len;
    logic                         r_sw, n_sw;
    logic                         r_last, n_last;
    sfsm_pkg::t_status            r_status, n_status;

    logic [END_W-1:0]   w_s;
    logic               w_is_xfer;
    logic               w_is_seek;
    logic [BLK_W-1:0]   w_sb;
    logic [MASK_W-1:0]  w_start_lo;
    logic [MASK_W-1:0]  w_end_lo;
    logic               w_hi_is_end;
    logic [MASK_W-1:0]  w_lo;
    logic               w_seg_last;
    logic [MASK_W:0]    w_hi;
    logic [ALU_W-1:0]   w_base;
    logic [ALU_W-1:0]   w_seek_base;
    logic               w_too_many;

    assign busy        = (r_state != sfsm_pkg::S_IDLE);
    assign o_cfg_ready = !busy;

    sfsm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    sfsm_alu u_alu (
        .i_req    (w_req),
        .o_result (w_sum)
    );

    assign w_is_xfer = (r_cmd == sfsm_pkg::CMD_XFER_AT_OFFSET)
                    || (r_cmd == sfsm_pkg::CMD_XFER_AT_POS);
    assign w_is_seek = (r_cmd == sfsm_pkg::CMD_SEEK_SET)
                    || (r_cmd == sfsm_pkg::CMD_SEEK_CUR)
                    || (r_cmd == sfsm_pkg::CMD_SEEK_END);
    assign w_s = (r_cmd == sfsm_pkg::CMD_XFER_AT_OFFSET) ? r_off : {1'b0, r_pos};

    assign w_sb        = BLK_W'(r_start >> w_cfg.shift);
    assign w_start_lo  = r_start[MASK_W-1:0] & w_cfg.mask;
    assign w_end_lo    = r_end[MASK_W-1:0] & w_cfg.mask;
    // the last segment ends inside its block unless the end is block aligned
    assign w_hi_is_end = (r_cnt == '0) || (w_end_lo != '0);
    assign w_lo        = r_first ? w_start_lo : '0;
    assign w_seg_last  = (r_left == '0);
    assign w_hi        = (w_seg_last && w_hi_is_end) ? {1'b0, w_end_lo} : w_cfg.size;
    assign w_base      = ALU_W'(r_blk) << w_cfg.shift;
    assign w_too_many  = (w_cfg.count == sfsm_pkg::CH_RESET)
                       ? (r_cnt > sfsm_pkg::MAX_SEG_LEN)
                       : (w_sum > ALU_W'(MAX_SEGMENTS - 1));

    always_comb begin
        unique case (r_cmd)
            sfsm_pkg::CMD_SEEK_CUR: w_seek_base = ALU_W'(r_pos);
            sfsm_pkg::CMD_SEEK_END: w_seek_base = ALU_W'(r_lend);
            default:                w_seek_base = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_wr     = r_wr;
        n_off    = r_off;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_lend   = r_lend;
        n_start  = r_start;
        n_end    = r_end;
        n_lastb  = r_lastb;
        n_blk    = r_blk;
        n_left   = r_left;
        n_first  = r_first;
        n_strobe = 1'b0;
        n_phys   = r_phys;
        n_len    = r_len;
        n_sw     = r_sw;
        n_last   = r_last;
        n_status = r_status;
        w_req.op  = sfsm_pkg::ALU_ADD;
        w_req.a   = '0;
        w_req.b   = '0;
        w_req.cin = 1'b0;
        w_req.c   = '0;

        unique case (r_state)
            sfsm_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_wr    = i_is_write;
                    n_off   = i_offset;
                    n_cnt   = i_byte_count;
                    n_state = sfsm_pkg::S_SUM;
                end
            end

            sfsm_pkg::S_SUM: begin
                n_strobe = 1'b1;
                n_phys   = '0;
                n_len    = '0;
                n_sw     = 1'b0;
                n_last   = 1'b1;
                n_status = sfsm_pkg::ST_OK;
                n_state  = sfsm_pkg::S_IDLE;
                if (w_is_xfer) begin
                    w_req.a = ALU_W'(w_s);
                    w_req.b = ALU_W'(r_cnt);
                    n_start = w_s[POS_W-1:0];
                    n_end   = w_sum[END_W-1:0];
                    n_sw    = r_wr;
                    if (w_s[END_W-1]) begin
                        n_status = sfsm_pkg::ST_NEG;
                    end else begin
                        n_strobe = 1'b0;
                        n_state  = sfsm_pkg::S_DEC;
                    end
                end else if (w_is_seek) begin
                    w_req.a = w_seek_base;
                    w_req.b = {{(ALU_W-sfsm_pkg::OFF_W){r_off[sfsm_pkg::OFF_W-1]}}, r_off};
                    if (w_sum[ALU_W-1]) begin
                        n_status = sfsm_pkg::ST_NEG;
                    end else if (|w_sum[ALU_W-2:POS_W]) begin
                        n_pos = '1;
                    end else begin
                        n_pos = w_sum[POS_W-1:0];
                    end
                end
            end

            sfsm_pkg::S_DEC: begin
                // end - 1 gives the last block touched by a nonempty transfer
                w_req.a = ALU_W'(r_end);
                w_req.b = '1;
                n_lastb = (r_cnt == '0) ? w_sb : BLK_W'(w_sum[END_W-1:0] >> w_cfg.shift);
                n_state = sfsm_pkg::S_SPAN;
            end

            sfsm_pkg::S_SPAN: begin
                w_req.a   = ALU_W'(r_lastb);
                w_req.b   = ~ALU_W'(w_sb);
                w_req.cin = 1'b1;
                if (w_too_many) begin
                    n_strobe = 1'b1;
                    n_phys   = '0;
                    n_len    = '0;
                    n_sw     = r_wr;
                    n_last   = 1'b1;
                    n_status = sfsm_pkg::ST_SPAN;
                    n_state  = sfsm_pkg::S_IDLE;
                end else begin
                    if (r_end > r_lend) begin
                        n_lend = r_end;
                    end
                    if (r_cmd == sfsm_pkg::CMD_XFER_AT_POS) begin
                        n_pos = r_end[END_W-1] ? '1 : r_end[POS_W-1:0];
                    end
                    if (w_cfg.count == sfsm_pkg::CH_RESET) begin
                        n_strobe = 1'b1;
                        n_phys   = sfsm_pkg::PHYS_W'(r_start);
                        n_len    = r_cnt[sfsm_pkg::LEN_W-1:0];
                        n_sw     = r_wr;
                        n_last   = 1'b1;
                        n_status = sfsm_pkg::ST_OK;
                        n_state  = sfsm_pkg::S_IDLE;
                    end else begin
                        n_left  = w_sum[LEFT_W-1:0];
                        n_first = 1'b1;
                        n_state = sfsm_pkg::S_MUL;
                    end
                end
            end

            sfsm_pkg::S_MUL: begin
                w_req.op = sfsm_pkg::ALU_MAC;
                w_req.a  = ALU_W'(w_sb);
                w_req.b  = ALU_W'(w_cfg.count);
                w_req.c  = w_cfg.index;
                n_blk    = w_sum[PROD_W-1:0];
                n_state  = sfsm_pkg::S_SEG;
            end

            sfsm_pkg::S_SEG: begin
                w_req.a  = w_base;
                w_req.b  = ALU_W'(w_lo);
                n_strobe = 1'b1;
                n_phys   = w_sum[sfsm_pkg::PHYS_W-1:0];
                n_len    = w_hi - {1'b0, w_lo};
                n_sw     = r_wr;
                n_last   = w_seg_last;
                n_status = sfsm_pkg::ST_OK;
                n_blk    = r_blk + PROD_W'(w_cfg.count);
                n_left   = r_left - LEFT_W'(1);
                n_first  = 1'b0;
                if (w_seg_last) begin
                    n_state = sfsm_pkg::S_IDLE;
                end
            end

            default: n_state = sfsm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sfsm_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_pos    <= '0;
            r_lend   <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pos    <= n_pos;
            r_lend   <= n_lend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_wr     <= n_wr;
        r_off    <= n_off;
        r_cnt    <= n_cnt;
        r_start  <= n_start;
        r_end    <= n_end;
        r_lastb  <= n_lastb;
        r_blk    <= n_blk;
        r_left   <= n_left;
        r_first  <= n_first;
        r_phys   <= n_phys;
        r_len    <= n_len;
        r_sw     <= n_sw;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_strobe      = r_strobe;
    assign o_phys_offset = r_phys;
    assign o_seg_length  = r_len;
    assign o_seg_write   = r_sw;
    assign o_last        = r_last;
    assign o_status      = r_status;
    assign o_position    = r_pos;

    // a newly taken request never has a result in the following cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result strobed right after request accept");

    // the final result of a request leaves the block idle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high on final result");

    // refused results carry no segment and end the request
    a_refusal_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != sfsm_pkg::ST_OK)) |->
            (o_seg_length == '0 && o_phys_offset == '0 && o_last))
        else $error("refused transaction carries a segment");

endmodule
